/* sv/packet_endpoint_redirect_classifier_defines.svh */
// Assertion macros shared by the classifier modules.
// ASSERT_IMPLIES: same-cycle implication, ASSERT_NEXT: next-cycle implication.
`ifndef PACKET_ENDPOINT_REDIRECT_CLASSIFIER_DEFINES_SVH
`define PACKET_ENDPOINT_REDIRECT_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("classifier implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("classifier next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/perc_pkg.sv */
`timescale 1ns / 1ps
package perc_pkg;

    // Transaction opcodes
    localparam logic OP_PACKET   = 1'b0;
    localparam logic OP_TABLE_WR = 1'b1;

    // Frame layout and protocol constants
    localparam logic [6:0]  COUNT_MAX  = 7'd127;
    localparam logic [6:0]  ETH_LEN    = 7'd14;
    localparam logic [6:0]  IP_MIN_END = 7'd34;
    localparam logic [6:0]  IDX_KIND_HI = 7'd12;
    localparam logic [6:0]  IDX_KIND_LO = 7'd13;
    localparam logic [6:0]  IDX_PROTO  = 7'd23;
    localparam logic [6:0]  IDX_SRC_LO = 7'd26;
    localparam logic [6:0]  IDX_SRC_HI = 7'd29;
    localparam logic [6:0]  IDX_DST_LO = 7'd30;
    localparam logic [6:0]  IDX_DST_HI = 7'd33;
    localparam logic [15:0] KIND_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  IHL_MASK   = 4'hf;
    localparam logic [5:0]  IP_MIN_HDR = 6'd20;
    localparam logic [6:0]  TCP_HDR    = 7'd20;
    localparam logic [6:0]  UDP_HDR    = 7'd8;

    // Verdict reasons
    typedef enum logic [2:0] {
        R_REDIRECT  = 3'd0,
        R_SHORT     = 3'd1,
        R_NOT_IPV4  = 3'd2,
        R_BAD_IHL   = 3'd3,
        R_NOT_L4    = 3'd4,
        R_NO_MATCH  = 3'd5,
        R_UNBOUND   = 3'd6
    } t_reason;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOKUP,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // take a frame byte
        logic table_wr;  // write an endpoint table slot
        logic start;     // latch header checks, reset lookup
        logic issue;     // read next table slot
        logic finish;    // load result register, clear frame state
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic lookup_needed;
        logic idx_last;
    } t_dp_status;

endpackage

/* sv/packet_endpoint_redirect_classifier.sv */
`timescale 1ns / 1ps
// A table write or a non-final frame byte completes in idle. A final byte goes to the check state,
// then, if the headers pass, to the lookup of every slot and the drain state, then to the finish
// state, which loads the result register; the load waits while an earlier result is still held.
// Throughput: one byte per cycle within a frame; after a final byte input stalls for the check
// and the sweep of the endpoint table, one slot a cycle through its single read port.
// Reset (synchronous, active low): clears control, frame state, slot valid bits and the mask.
module packet_endpoint_redirect_classifier
    import perc_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int QUEUE_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [5:0]  i_rx_queue,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_slot_addr,
    input  logic [15:0] i_slot_port,
    input  logic        i_slot_valid,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic [5:0]  o_target_queue,
    output logic        o_source_hit,
    output logic        o_dest_hit,
    output logic [2:0]  o_reason
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    perc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Parser, endpoint table and verdict logic
    perc_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_data_byte    (i_data_byte),
        .i_rx_queue     (i_rx_queue),
        .i_slot_index   (i_slot_index),
        .i_slot_addr    (i_slot_addr),
        .i_slot_port    (i_slot_port),
        .i_slot_valid   (i_slot_valid),
        .o_verdict      (o_verdict),
        .o_target_queue (o_target_queue),
        .o_source_hit   (o_source_hit),
        .o_dest_hit     (o_dest_hit),
        .o_reason       (o_reason)
    );

endmodule

/* sv/perc_datapath.sv */
`timescale 1ns / 1ps
module perc_datapath
    import perc_pkg::*;
#(
    parameter int TABLE_SLOTS = 16,
    parameter int QUEUE_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_rx_queue,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_slot_addr,
    input  logic [15:0] i_slot_port,
    input  logic        i_slot_valid,
    output logic        o_verdict,
    output logic [5:0]  o_target_queue,
    output logic        o_source_hit,
    output logic        o_dest_hit,
    output logic [2:0]  o_reason
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Configuration and frame state
    logic [63:0] r_mask;
    logic [6:0]  r_byte_count;
    logic [15:0] r_ether_kind;
    logic [5:0]  r_header_len;
    logic [7:0]  r_proto_kind;
    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic [5:0]  r_queue;

    // Endpoint table: contents in memory, valid bits in flops
    logic [31:0] mem_addr [TABLE_SLOTS];
    logic [15:0] mem_port [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_tvalid;

    // Lookup sweep
    logic [IW-1:0] r_idx;
    logic [31:0]   r_rd_addr;
    logic [15:0]   r_rd_port;
    logic          r_rd_vld;
    logic          r_src_hit;
    logic          r_dst_hit;
    t_reason       r_pre_reason;

    // Result register
    logic          r_verdict;
    logic [5:0]    r_target;
    logic          r_out_src_hit;
    logic          r_out_dst_hit;
    t_reason       r_reason;

    logic [8:0]    w_slot_ext;
    logic          w_slot_ok;
    logic [6:0]    w_l4;
    logic [6:0]    w_need;
    logic          w_tcp;
    logic          w_udp;
    logic          w_bound;
    logic          w_src_match;
    logic          w_dst_match;
    t_reason       w_pre_reason;
    t_reason       w_reason;

    // Slot write range check
    assign w_slot_ext = {5'd0, i_slot_index};
    assign w_slot_ok  = (w_slot_ext < 9'(TABLE_SLOTS));

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_wr_en) begin
            r_mask <= i_cfg_wr_data;
        end
    end

    // Header field capture
    assign w_l4 = ETH_LEN + {1'b0, r_header_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_byte_count <= '0;
            r_ether_kind <= '0;
            r_header_len <= '0;
            r_proto_kind <= '0;
            r_src_addr   <= '0;
            r_dst_addr   <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
        end else if (i_cmd.capture) begin
            if (r_byte_count == IDX_KIND_HI || r_byte_count == IDX_KIND_LO) begin
                r_ether_kind <= {r_ether_kind[7:0], i_data_byte};
            end else if (r_byte_count == ETH_LEN) begin
                r_header_len <= {i_data_byte[3:0] & IHL_MASK, 2'b00};
            end else if (r_byte_count == IDX_PROTO) begin
                r_proto_kind <= i_data_byte;
            end else if (r_byte_count >= IDX_SRC_LO && r_byte_count <= IDX_SRC_HI) begin
                r_src_addr <= {r_src_addr[23:0], i_data_byte};
            end else if (r_byte_count >= IDX_DST_LO && r_byte_count <= IDX_DST_HI) begin
                r_dst_addr <= {r_dst_addr[23:0], i_data_byte};
            end
            if (r_byte_count > ETH_LEN) begin
                if (r_byte_count == w_l4 || r_byte_count == w_l4 + 7'd1) begin
                    r_src_port <= {r_src_port[7:0], i_data_byte};
                end else if (r_byte_count == w_l4 + 7'd2 || r_byte_count == w_l4 + 7'd3) begin
                    r_dst_port <= {r_dst_port[7:0], i_data_byte};
                end
            end
            if (r_byte_count < COUNT_MAX) begin
                r_byte_count <= r_byte_count + 7'd1;
            end
        end
    end

    // Receive queue of the latest byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_queue <= i_rx_queue;
        end
    end

    // Header checks, in priority order
    assign w_tcp  = (r_proto_kind == PROTO_TCP);
    assign w_udp  = (r_proto_kind == PROTO_UDP);
    assign w_need = ETH_LEN + {1'b0, r_header_len} + (w_tcp ? TCP_HDR : UDP_HDR);

    always_comb begin
        if (r_byte_count < ETH_LEN) begin
            w_pre_reason = R_SHORT;
        end else if (r_ether_kind != KIND_IPV4) begin
            w_pre_reason = R_NOT_IPV4;
        end else if (r_byte_count < IP_MIN_END) begin
            w_pre_reason = R_SHORT;
        end else if (r_header_len < IP_MIN_HDR) begin
            w_pre_reason = R_BAD_IHL;
        end else if (!w_tcp && !w_udp) begin
            w_pre_reason = R_NOT_L4;
        end else if (r_byte_count < w_need) begin
            w_pre_reason = R_SHORT;
        end else begin
            w_pre_reason = R_NO_MATCH;
        end
    end

    assign o_status.lookup_needed = (w_pre_reason == R_NO_MATCH);
    assign o_status.idx_last      = (r_idx == IW'(TABLE_SLOTS - 1));

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.table_wr && w_slot_ok) begin
            mem_addr[w_slot_ext[IW-1:0]] <= i_slot_addr;
            mem_port[w_slot_ext[IW-1:0]] <= i_slot_port;
        end
        if (i_cmd.issue) begin
            r_rd_addr <= mem_addr[r_idx];
            r_rd_port <= mem_port[r_idx];
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else if (i_cmd.table_wr && w_slot_ok) begin
            r_tvalid[w_slot_ext[IW-1:0]] <= i_slot_valid;
        end
    end

    // Lookup sweep: index counter, read valid, hit accumulation
    assign w_src_match = r_rd_vld && (r_rd_addr == r_src_addr) && (r_rd_port == r_src_port);
    assign w_dst_match = r_rd_vld && (r_rd_addr == r_dst_addr) && (r_rd_port == r_dst_port);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_src_hit    <= 1'b0;
            r_dst_hit    <= 1'b0;
            r_pre_reason <= R_NO_MATCH;
        end else begin
            r_rd_vld <= i_cmd.issue && r_tvalid[r_idx];
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_src_hit    <= 1'b0;
                r_dst_hit    <= 1'b0;
                r_pre_reason <= w_pre_reason;
            end else begin
                if (i_cmd.issue) begin
                    r_idx <= r_idx + IW'(1);
                end
                r_src_hit <= r_src_hit | w_src_match;
                r_dst_hit <= r_dst_hit | w_dst_match;
            end
        end
    end

    // Final verdict
    assign w_bound = ({1'b0, r_queue} < 7'(QUEUE_COUNT)) && r_mask[r_queue];

    always_comb begin
        if (r_pre_reason != R_NO_MATCH) begin
            w_reason = r_pre_reason;
        end else if (!r_src_hit && !r_dst_hit) begin
            w_reason = R_NO_MATCH;
        end else if (!w_bound) begin
            w_reason = R_UNBOUND;
        end else begin
            w_reason = R_REDIRECT;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_reason      <= w_reason;
            r_verdict     <= (w_reason == R_REDIRECT);
            r_target      <= (w_reason == R_REDIRECT) ? r_queue : 6'd0;
            r_out_src_hit <= r_src_hit;
            r_out_dst_hit <= r_dst_hit;
        end
    end

    assign o_verdict      = r_verdict;
    assign o_target_queue = r_target;
    assign o_source_hit   = r_out_src_hit;
    assign o_dest_hit     = r_out_dst_hit;
    assign o_reason       = r_reason;

`include "packet_endpoint_redirect_classifier_defines.svh"

    // Hits are only seen when the header checks let the lookup run
    `ASSERT_IMPLIES(a_hits_need_lookup, i_clk, i_rst_n, (r_src_hit || r_dst_hit), (r_pre_reason == R_NO_MATCH))
    // A read result is valid only the cycle after an issued read
    `ASSERT_IMPLIES(a_rd_after_issue, i_clk, i_rst_n, r_rd_vld, $past(i_cmd.issue))
    // A loaded result redirects exactly when its reason says so
    `ASSERT_NEXT(a_verdict_reason, i_clk, i_rst_n, i_cmd.finish, (r_verdict == (r_reason == R_REDIRECT)))

endmodule

/* sv/perc_ctrl.sv */
`timescale 1ns / 1ps
module perc_ctrl
    import perc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    // State register and output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_opcode == OP_PACKET && i_last_byte) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.lookup_needed ? S_LOOKUP : S_FINISH;
            end
            S_LOOKUP: begin
                if (i_status.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.capture  = w_accept && (i_opcode == OP_PACKET);
                o_cmd.table_wr = w_accept && (i_opcode == OP_TABLE_WR);
            end
            S_CHECK:  o_cmd.start  = 1'b1;
            S_LOOKUP: o_cmd.issue  = 1'b1;
            S_DRAIN:  o_cmd        = '0;
            S_FINISH: o_cmd.finish = w_out_free;
            default:  o_cmd        = '0;
        endcase
    end

    // Result held until the consumer takes it
    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`include "packet_endpoint_redirect_classifier_defines.svh"

    // A new result appears only out of the finish state
    `ASSERT_IMPLIES(a_result_from_finish, i_clk, i_rst_n, (o_cmd.finish), (r_state == S_FINISH))
    // The last byte of a frame always leads into the header check
    `ASSERT_NEXT(a_last_to_check, i_clk, i_rst_n, (o_cmd.capture && i_last_byte), (r_state == S_CHECK))
    // The finishing step never overwrites a result that is still waiting
    `ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready), (!$past(o_cmd.finish)))

endmodule
